FILE: hw/rtl/sound_log_command_parser_defines.svh
// Assertion macros used by the checker file of the command parser.
`ifndef SOUND_LOG_COMMAND_PARSER_DEFINES_SVH
`define SOUND_LOG_COMMAND_PARSER_DEFINES_SVH

// Check a same-cycle implication, held off during reset.
`define SLCP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle, held off during reset.
`define SLCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/slcp_pkg.sv
// Types and constants of the sound-log command parser.
`default_nettype none

package slcp_pkg;

  typedef enum logic [2:0] {
    KIND_CHIP_WRITE = 3'd0,
    KIND_WAIT       = 3'd1,
    KIND_END        = 3'd2,
    KIND_ROM_SETUP  = 3'd3,
    KIND_ROM_BYTE   = 3'd4,
    KIND_UNHANDLED  = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_DATA1     = 4'd1,
    PH_ADDR      = 4'd2,
    PH_DATA2     = 4'd3,
    PH_WAIT_LO   = 4'd4,
    PH_WAIT_HI   = 4'd5,
    PH_BLK_SKIP  = 4'd6,
    PH_BLK_TYPE  = 4'd7,
    PH_BLK_SIZE  = 4'd8,
    PH_ROM_TOTAL = 4'd9,
    PH_ROM_START = 4'd10,
    PH_ROM_DATA  = 4'd11,
    PH_SKIP_DATA = 4'd12
  } phase_e;

  localparam logic [2:0] CHIP_PSG     = 3'd0;
  localparam logic [2:0] CHIP_FM_DUAL = 3'd1;
  localparam logic [2:0] CHIP_FM_ONE  = 3'd2;
  localparam logic [2:0] CHIP_PCM     = 3'd3;
  localparam logic [2:0] CHIP_APU     = 3'd4;

  localparam logic [7:0] OP_PSG_A    = 8'h4F;
  localparam logic [7:0] OP_PSG_B    = 8'h50;
  localparam logic [7:0] OP_FM_BANK0 = 8'h52;
  localparam logic [7:0] OP_FM_BANK1 = 8'h53;
  localparam logic [7:0] OP_FM_ONE   = 8'h54;
  localparam logic [7:0] OP_PCM      = 8'hBA;
  localparam logic [7:0] OP_APU      = 8'hB4;
  localparam logic [7:0] OP_WAIT_N   = 8'h61;
  localparam logic [7:0] OP_WAIT_NTSC = 8'h62;
  localparam logic [7:0] OP_WAIT_PAL = 8'h63;
  localparam logic [7:0] OP_END      = 8'h66;
  localparam logic [7:0] OP_BLOCK    = 8'h67;
  localparam logic [3:0] OP_WAIT_SHORT_HI = 4'h7;
  localparam logic [7:0] ROM_TYPE    = 8'h8E;

  localparam logic [15:0] WAIT_NTSC_COUNT = 16'd735;
  localparam logic [15:0] WAIT_PAL_COUNT  = 16'd882;

  localparam logic [16:0] RATE_RESET = 17'd44100;

  // floor(p / 44100) == floor(floor(p / 4) * RECIP_11025 / 2^45) for p < 2^33
  localparam logic [31:0] RECIP_11025 = 32'd3191326267;
  localparam int unsigned RECIP_SHIFT = 45;

  localparam int unsigned PROD_W = 33;
  localparam int unsigned WAIT_W = 18;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  chip;
    logic        bank;
    logic [7:0]  reg_address;
    logic [7:0]  reg_data;
    logic [31:0] rom_address;
    logic [31:0] rom_total_size;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/slcp_parser.sv
// Command stream state machine: decodes one byte per request and forms the result.
`default_nettype none

module slcp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         byte_i,
  input  logic [16:0]        rate_i,
  output logic               emit_o,
  output slcp_pkg::res_t     res_o,
  output logic [32:0]        product_o
);
  import slcp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [7:0]  held_q, held_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] len_q, len_d;
  logic [31:0] start_q, start_d;
  logic [31:0] size_q, size_d;
  logic        halted_q, halted_d;
  logic        emit;
  res_t        res;
  logic [15:0] count;

  function automatic logic [31:0] put_byte(logic [31:0] word, logic [1:0] lane,
                                           logic [7:0] b);
    logic [31:0] r;
    r = word;
    r[{lane, 3'b000} +: 8] = b;
    return r;
  endfunction

  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    held_d   = held_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    start_d  = start_q;
    size_d   = size_q;
    halted_d = halted_q;
    emit     = 1'b0;
    count    = '0;
    res      = '{kind: KIND_CHIP_WRITE, chip: CHIP_PSG, default: '0};

    case (phase_q)
      PH_IDLE: begin
        opcode_d = byte_i;
        if (byte_i == OP_PSG_A || byte_i == OP_PSG_B) begin
          phase_d = PH_DATA1;
        end else if (byte_i == OP_FM_BANK0 || byte_i == OP_FM_BANK1 ||
                     byte_i == OP_FM_ONE || byte_i == OP_PCM || byte_i == OP_APU) begin
          phase_d = PH_ADDR;
        end else if (byte_i == OP_WAIT_N) begin
          phase_d = PH_WAIT_LO;
        end else if (byte_i == OP_WAIT_NTSC) begin
          emit     = 1'b1;
          res.kind = KIND_WAIT;
          count    = WAIT_NTSC_COUNT;
        end else if (byte_i == OP_WAIT_PAL) begin
          emit     = 1'b1;
          res.kind = KIND_WAIT;
          count    = WAIT_PAL_COUNT;
        end else if (byte_i[7:4] == OP_WAIT_SHORT_HI) begin
          emit     = 1'b1;
          res.kind = KIND_WAIT;
          count    = {12'd0, byte_i[3:0]} + 16'd1;
        end else if (byte_i == OP_END) begin
          emit     = 1'b1;
          halted_d = 1'b1;
          res.kind = KIND_END;
        end else if (byte_i == OP_BLOCK) begin
          phase_d = PH_BLK_SKIP;
        end else begin
          emit         = 1'b1;
          res.kind     = KIND_UNHANDLED;
          res.reg_data = byte_i;
        end
      end
      PH_DATA1: begin
        phase_d      = PH_IDLE;
        emit         = 1'b1;
        res.reg_data = byte_i;
      end
      PH_ADDR: begin
        held_d  = byte_i;
        phase_d = PH_DATA2;
      end
      PH_DATA2: begin
        phase_d         = PH_IDLE;
        emit            = 1'b1;
        res.reg_address = held_q;
        res.reg_data    = byte_i;
        case (opcode_q)
          OP_FM_BANK0: res.chip = CHIP_FM_DUAL;
          OP_FM_BANK1: begin
            res.chip = CHIP_FM_DUAL;
            res.bank = 1'b1;
          end
          OP_FM_ONE:   res.chip = CHIP_FM_ONE;
          OP_PCM:      res.chip = CHIP_PCM;
          OP_APU:      res.chip = CHIP_APU;
          default:     res.chip = CHIP_PSG;
        endcase
      end
      PH_WAIT_LO: begin
        held_d  = byte_i;
        phase_d = PH_WAIT_HI;
      end
      PH_WAIT_HI: begin
        phase_d  = PH_IDLE;
        emit     = 1'b1;
        res.kind = KIND_WAIT;
        count    = {byte_i, held_q};
      end
      PH_BLK_SKIP: begin
        phase_d = PH_BLK_TYPE;
      end
      PH_BLK_TYPE: begin
        held_d  = byte_i;
        cnt_d   = '0;
        len_d   = '0;
        phase_d = PH_BLK_SIZE;
      end
      PH_BLK_SIZE: begin
        len_d = put_byte(len_q, cnt_q[1:0], byte_i);
        cnt_d = cnt_q + 32'd1;
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d = '0;
          if (held_q == ROM_TYPE) begin
            phase_d = PH_ROM_TOTAL;
          end else if (len_d == '0) begin
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_SKIP_DATA;
          end
        end
      end
      PH_ROM_TOTAL: begin
        size_d = put_byte(size_q, cnt_q[1:0], byte_i);
        cnt_d  = cnt_q + 32'd1;
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d   = '0;
          phase_d = PH_ROM_START;
        end
      end
      PH_ROM_START: begin
        start_d = put_byte(start_q, cnt_q[1:0], byte_i);
        cnt_d   = cnt_q + 32'd1;
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d              = '0;
          len_d              = (len_q >= 32'd8) ? len_q - 32'd8 : '0;
          phase_d            = (len_d == '0) ? PH_IDLE : PH_ROM_DATA;
          emit               = 1'b1;
          res.kind           = KIND_ROM_SETUP;
          res.rom_address    = start_d;
          res.rom_total_size = size_q;
        end
      end
      PH_ROM_DATA: begin
        cnt_d              = cnt_q + 32'd1;
        if (cnt_d >= len_q) begin
          phase_d = PH_IDLE;
        end
        emit               = 1'b1;
        res.kind           = KIND_ROM_BYTE;
        res.reg_data       = byte_i;
        res.rom_address    = start_q + cnt_q;
        res.rom_total_size = size_q;
      end
      PH_SKIP_DATA: begin
        if (len_q != '0) begin
          len_d = len_q - 32'd1;
        end
        if (len_d == '0) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      opcode_q <= '0;
      held_q   <= '0;
      cnt_q    <= '0;
      len_q    <= '0;
      start_q  <= '0;
      size_q   <= '0;
      halted_q <= 1'b0;
    end else if (fire_i && !halted_q) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      held_q   <= held_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      start_q  <= start_d;
      size_q   <= size_d;
      halted_q <= halted_d;
    end
  end

  assign emit_o    = fire_i && !halted_q && emit;
  assign res_o     = res;
  assign product_o = {17'd0, count} * {16'd0, rate_i};

endmodule

`default_nettype wire

FILE: hw/rtl/slcp_scaler.sv
// Divide the scaled wait product by 44100 through a constant reciprocal.
`default_nettype none

module slcp_scaler (
  input  logic [slcp_pkg::PROD_W-1:0] product_i,
  output logic [slcp_pkg::WAIT_W-1:0] wait_o
);
  import slcp_pkg::*;

  logic [PROD_W-3:0] quarter;
  logic [62:0]       full;

  // Drop the factor of four first, then multiply by the reciprocal of 11025.
  assign quarter = product_i[PROD_W-1:2];
  assign full    = {32'd0, quarter} * {31'd0, RECIP_11025};
  assign wait_o  = full[RECIP_SHIFT +: WAIT_W];

endmodule

`default_nettype wire

FILE: hw/rtl/sound_log_command_parser.sv
// Top level of the sound-log command parser: input, scale and result registers.
//
// Feed the command stream one byte per request on in_valid_i/in_ready_o with
// stream_byte_i. Decoded results leave on out_valid_o/out_ready_i, one field
// per port: chip writes, scaled waits, the end mark, ROM setup, ROM bytes and
// unhandled opcodes. Data block header bytes, but for the last one of a ROM
// header, and skipped block bytes produce no result. A result passes the
// input register, the parse and multiply stage and the divide stage before
// it shows on out_valid_o. Throughput: one byte per cycle unless the output
// stalls, limited by the single parse stage that updates the stream state
// once per byte. Each stage holds its request while the stage after it is
// full and stalled; a stalled receiver backs up the pipe one stage at a time,
// so up to three requests sit inside before in_ready_o drops.
// Write the output rate with cfg_we_i/cfg_wdata_i only while no request is in
// flight. Reset clears the pipe, returns the parser to awaiting an opcode and
// loads a rate of 44100. After the end opcode the block keeps taking bytes and
// drops them until the next reset.
`default_nettype none

module sound_log_command_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [2:0]  chip_o,
  output logic        bank_o,
  output logic [7:0]  reg_address_o,
  output logic [7:0]  reg_data_o,
  output logic [17:0] wait_samples_o,
  output logic [31:0] rom_address_o,
  output logic [31:0] rom_total_size_o
);
  import slcp_pkg::*;

  logic [16:0]       rate_q;

  logic              in_valid_q;
  logic [7:0]        in_byte_q;

  logic              mid_valid_q;
  res_t              mid_res_q;
  logic [PROD_W-1:0] mid_prod_q;

  logic              out_valid_q;
  res_t              out_res_q;
  logic [WAIT_W-1:0] out_wait_q;

  logic              out_free;
  logic              mid_free;
  logic              fire;
  logic              emit;
  res_t              parse_res;
  logic [PROD_W-1:0] parse_prod;
  logic [WAIT_W-1:0] scaled_wait;

  // A stage may load when it is empty or its content moves on this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign mid_free   = !mid_valid_q || out_free;
  assign in_ready_o = !in_valid_q || mid_free;
  assign fire       = in_valid_q && mid_free;

  // Hold the rate; the host must write it only while the pipe is empty, which the block itself does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else if (cfg_we_i) begin
      rate_q <= cfg_wdata_i;
    end
  end

  slcp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .byte_i    (in_byte_q),
    .rate_i    (rate_q),
    .emit_o    (emit),
    .res_o     (parse_res),
    .product_o (parse_prod)
  );

  slcp_scaler u_scaler (
    .product_i (mid_prod_q),
    .wait_o    (scaled_wait)
  );

  // Advance valid flags; a byte that yields nothing leaves a bubble behind.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (mid_free) begin
        mid_valid_q <= emit;
      end
      if (out_free) begin
        out_valid_q <= mid_valid_q;
      end
    end
  end

  // Payload registers load alongside their valid flags.
  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      in_byte_q <= stream_byte_i;
    end
    if (mid_free) begin
      mid_res_q  <= parse_res;
      mid_prod_q <= parse_prod;
    end
    if (out_free) begin
      out_res_q  <= mid_res_q;
      out_wait_q <= scaled_wait;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_res_q.kind;
  assign chip_o           = out_res_q.chip;
  assign bank_o           = out_res_q.bank;
  assign reg_address_o    = out_res_q.reg_address;
  assign reg_data_o       = out_res_q.reg_data;
  assign wait_samples_o   = out_wait_q;
  assign rom_address_o    = out_res_q.rom_address;
  assign rom_total_size_o = out_res_q.rom_total_size;

endmodule

`default_nettype wire

FILE: hw/rtl/slcp_checker.sv
// Port-level checks of the command parser and their bind to the top level.
`default_nettype none

`include "sound_log_command_parser_defines.svh"

module slcp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  kind_i,
  input  logic [2:0]  chip_i,
  input  logic        bank_i,
  input  logic [17:0] wait_samples_i,
  input  logic [31:0] rom_address_i,
  input  logic [31:0] rom_total_size_i
);
  import slcp_pkg::*;

  `SLCP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `SLCP_ASSERT_NEXT(a_end_last, clk_i, rst_ni, out_valid_i && out_ready_i && kind_i == KIND_END, !out_valid_i, "result after end mark")
  `SLCP_ASSERT_SAME(a_wait_only, clk_i, rst_ni, out_valid_i && kind_i != KIND_WAIT, wait_samples_i == '0, "wait length on a non-wait result")
  `SLCP_ASSERT_SAME(a_rom_only, clk_i, rst_ni, out_valid_i && kind_i != KIND_ROM_SETUP && kind_i != KIND_ROM_BYTE, rom_address_i == '0 && rom_total_size_i == '0, "ROM fields on a non-ROM result")
  `SLCP_ASSERT_SAME(a_bank_fm, clk_i, rst_ni, out_valid_i && bank_i, kind_i == KIND_CHIP_WRITE && chip_i == CHIP_FM_DUAL, "bank set outside two-bank FM write")

endmodule

bind sound_log_command_parser slcp_checker u_slcp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .kind_i           (kind_o),
  .chip_i           (chip_o),
  .bank_i           (bank_o),
  .wait_samples_i   (wait_samples_o),
  .rom_address_i    (rom_address_o),
  .rom_total_size_i (rom_total_size_o)
);

`default_nettype wire

FILE: tb/sound_log_command_parser_watch.sv
// Channel monitor for the command parser: decodes accepted bytes and checks each result.
module sound_log_command_parser_watch (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  stream_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  kind_i,
  input  logic [2:0]  chip_i,
  input  logic        bank_i,
  input  logic [7:0]  reg_address_i,
  input  logic [7:0]  reg_data_i,
  input  logic [17:0] wait_samples_i,
  input  logic [31:0] rom_address_i,
  input  logic [31:0] rom_total_size_i,
  output int unsigned pending_o,
  output int unsigned mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import slcp_pkg::*;

  localparam logic [63:0] BASE_RATE = 64'd44100;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  chip;
    logic        bank;
    logic [7:0]  reg_address;
    logic [7:0]  reg_data;
    logic [17:0] wait_samples;
    logic [31:0] rom_address;
    logic [31:0] rom_total_size;
  } decoded_t;

  // Decoded results that the block still owes, oldest first.
  decoded_t    decoded_q[$];

  logic [16:0] rate_q;
  phase_e      phase_q;
  logic [7:0]  opcode_q;
  logic [7:0]  held_q;
  logic [7:0]  blk_type_q;
  logic [31:0] count_q;
  logic [31:0] length_q;
  logic [31:0] rom_start_q;
  logic [31:0] rom_size_q;
  logic        halted_q;
  int unsigned mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
  endtask

  function automatic decoded_t blank_result(input kind_e kind);
    decoded_t r;
    r = '0;
    r.kind = kind;
    return r;
  endfunction

  function automatic decoded_t wait_result(input logic [15:0] count);
    decoded_t    r;
    logic [63:0] prod;
    r = blank_result(KIND_WAIT);
    prod = 64'(count) * 64'(rate_q);
    r.wait_samples = 18'(prod / BASE_RATE);
    return r;
  endfunction

  function automatic logic [2:0] chip_for(input logic [7:0] op);
    case (op)
      OP_FM_BANK0, OP_FM_BANK1: return CHIP_FM_DUAL;
      OP_FM_ONE:                return CHIP_FM_ONE;
      OP_PCM:                   return CHIP_PCM;
      OP_APU:                   return CHIP_APU;
      default:                  return CHIP_PSG;
    endcase
  endfunction

  // Advance the stream state by one byte and queue the result it yields, if any.
  task automatic decode_byte(input logic [7:0] b);
    decoded_t    r;
    logic [31:0] lane;
    lane = {24'd0, b} << (8 * count_q[1:0]);
    if (!halted_q) begin
      case (phase_q)
        PH_IDLE: begin
          opcode_q = b;
          if (b == OP_PSG_A || b == OP_PSG_B) begin
            phase_q = PH_DATA1;
          end else if (b inside {OP_FM_BANK0, OP_FM_BANK1, OP_FM_ONE, OP_PCM, OP_APU}) begin
            phase_q = PH_ADDR;
          end else if (b == OP_WAIT_N) begin
            phase_q = PH_WAIT_LO;
          end else if (b == OP_WAIT_NTSC) begin
            decoded_q.push_back(wait_result(WAIT_NTSC_COUNT));
          end else if (b == OP_WAIT_PAL) begin
            decoded_q.push_back(wait_result(WAIT_PAL_COUNT));
          end else if (b[7:4] == OP_WAIT_SHORT_HI) begin
            decoded_q.push_back(wait_result(16'(b[3:0]) + 16'd1));
          end else if (b == OP_END) begin
            halted_q = 1'b1;
            decoded_q.push_back(blank_result(KIND_END));
          end else if (b == OP_BLOCK) begin
            phase_q = PH_BLK_SKIP;
          end else begin
            r = blank_result(KIND_UNHANDLED);
            r.reg_data = b;
            decoded_q.push_back(r);
          end
        end
        PH_DATA1: begin
          phase_q = PH_IDLE;
          r = blank_result(KIND_CHIP_WRITE);
          r.reg_data = b;
          decoded_q.push_back(r);
        end
        PH_ADDR: begin
          held_q = b;
          phase_q = PH_DATA2;
        end
        PH_DATA2: begin
          phase_q = PH_IDLE;
          r = blank_result(KIND_CHIP_WRITE);
          r.chip = chip_for(opcode_q);
          r.bank = (opcode_q == OP_FM_BANK1);
          r.reg_address = held_q;
          r.reg_data = b;
          decoded_q.push_back(r);
        end
        PH_WAIT_LO: begin
          held_q = b;
          phase_q = PH_WAIT_HI;
        end
        PH_WAIT_HI: begin
          phase_q = PH_IDLE;
          decoded_q.push_back(wait_result({b, held_q}));
        end
        PH_BLK_SKIP: phase_q = PH_BLK_TYPE;
        PH_BLK_TYPE: begin
          blk_type_q = b;
          held_q = b;
          count_q = '0;
          length_q = '0;
          phase_q = PH_BLK_SIZE;
        end
        PH_BLK_SIZE: begin
          length_q = length_q | lane;
          count_q = count_q + 1;
          if (count_q == 32'd4) begin
            count_q = '0;
            if (blk_type_q == ROM_TYPE) begin
              rom_size_q = '0;
              phase_q = PH_ROM_TOTAL;
            end else begin
              phase_q = (length_q == 0) ? PH_IDLE : PH_SKIP_DATA;
            end
          end
        end
        PH_ROM_TOTAL: begin
          rom_size_q = rom_size_q | lane;
          count_q = count_q + 1;
          if (count_q >= 32'd4) begin
            count_q = '0;
            rom_start_q = '0;
            phase_q = PH_ROM_START;
          end
        end
        PH_ROM_START: begin
          rom_start_q = rom_start_q | lane;
          count_q = count_q + 1;
          if (count_q == 32'd4) begin
            count_q = '0;
            // A size below the header length leaves no ROM bytes at all.
            length_q = (length_q >= 32'd8) ? length_q - 32'd8 : '0;
            phase_q = (length_q == 0) ? PH_IDLE : PH_ROM_DATA;
            r = blank_result(KIND_ROM_SETUP);
            r.rom_address = rom_start_q;
            r.rom_total_size = rom_size_q;
            decoded_q.push_back(r);
          end
        end
        PH_ROM_DATA: begin
          r = blank_result(KIND_ROM_BYTE);
          r.reg_data = b;
          r.rom_address = rom_start_q + count_q;
          r.rom_total_size = rom_size_q;
          count_q = count_q + 1;
          if (count_q >= length_q) phase_q = PH_IDLE;
          decoded_q.push_back(r);
        end
        PH_SKIP_DATA: begin
          if (length_q > 0) length_q = length_q - 1;
          if (length_q == 0) phase_q = PH_IDLE;
        end
        default: phase_q = PH_IDLE;
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    decoded_t want;
    if (!rst_ni) begin
      rate_q = RATE_RESET;
      phase_q = PH_IDLE;
      opcode_q = '0;
      held_q = '0;
      blk_type_q = '0;
      count_q = '0;
      length_q = '0;
      rom_start_q = '0;
      rom_size_q = '0;
      halted_q = 1'b0;
      decoded_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) rate_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) decode_byte(stream_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("result of kind %0d arrived with none owed", kind_i));
        end else begin
          want = decoded_q.pop_front();
          check_field("kind", kind_i, want.kind);
          check_field("chip", chip_i, want.chip);
          check_field("bank", bank_i, want.bank);
          check_field("reg_address", reg_address_i, want.reg_address);
          check_field("reg_data", reg_data_i, want.reg_data);
          check_field("wait_samples", wait_samples_i, want.wait_samples);
          check_field("rom_address", rom_address_i, want.rom_address);
          check_field("rom_total_size", rom_total_size_i, want.rom_total_size);
        end
      end
      pending_o <= decoded_q.size();
    end
  end

endmodule

FILE: tb/tb_sound_log_command_parser.sv
// Testbench top for the sound-log command parser: stimulus, handshake pacing and verdict.
module tb_sound_log_command_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import slcp_pkg::*;

  // Roughly how many stream bytes to push through, spread over the rate phases.
  localparam int unsigned TOTAL_BYTES  = 1300;
  localparam int unsigned RATE_PHASES  = 7;
  // Cycles to hold after the last owed result: covers the input register and
  // the two pipeline stages, with margin.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 20000;

  localparam logic [7:0] ADDRESSED_OPS [5] = '{OP_FM_BANK0, OP_FM_BANK1, OP_FM_ONE,
                                               OP_PCM, OP_APU};
  // Fixed rates per phase: band edges, zero, the widest 17-bit value and one.
  localparam logic [16:0] FIXED_RATES [5] = '{17'd8000, 17'd96000, 17'd0, 17'h1FFFF,
                                              17'd1};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  stream_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  kind_o;
  logic [2:0]  chip_o;
  logic        bank_o;
  logic [7:0]  reg_address_o;
  logic [7:0]  reg_data_o;
  logic [17:0] wait_samples_o;
  logic [31:0] rom_address_o;
  logic [31:0] rom_total_size_o;

  int unsigned owed_results;
  int unsigned mismatches;
  int unsigned bytes_sent = 0;
  bit          send_calm = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sound_log_command_parser dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .stream_byte_i    (stream_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .chip_o           (chip_o),
    .bank_o           (bank_o),
    .reg_address_o    (reg_address_o),
    .reg_data_o       (reg_data_o),
    .wait_samples_o   (wait_samples_o),
    .rom_address_o    (rom_address_o),
    .rom_total_size_o (rom_total_size_o)
  );

  sound_log_command_parser_watch stream_watch (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .stream_byte_i    (stream_byte_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_i           (kind_o),
    .chip_i           (chip_o),
    .bank_i           (bank_o),
    .reg_address_i    (reg_address_o),
    .reg_data_i       (reg_data_o),
    .wait_samples_i   (wait_samples_o),
    .rom_address_i    (rom_address_o),
    .rom_total_size_i (rom_total_size_o),
    .pending_o        (owed_results),
    .mismatches_o     (mismatches)
  );

  // Offer one byte as a request and return at the edge that accepts it.
  // Valid is dropped only for a drawn gap; with no gap it stays high and the
  // next byte replaces the old one at the accepting edge, so each edge sees
  // at most one update of valid.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    // Flip between paced and back-to-back stretches now and then.
    if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    stream_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
  endtask

  // Drop valid, wait until every owed result has come back, then let the
  // pipe settle; a trailing header byte gives no result to wait on.
  task automatic wait_drained();
    int unsigned cycles;
    cycles = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      cycles++;
    end while (owed_results != 0 && cycles < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [16:0] rate);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= rate;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Data block carrying ROM contents: header, total size, start, then bytes.
  // Mostly a handful of bytes; sometimes a size below the header length so
  // only the setup result comes out. Starts near the top exercise wrap.
  task automatic send_rom_block();
    logic [31:0] size;
    logic [31:0] start;
    size = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : 8 + $urandom_range(0, 16);
    start = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 8) : $urandom();
    send_byte(OP_BLOCK);
    send_byte(8'($urandom()));
    send_byte(ROM_TYPE);
    send_word(size);
    send_word($urandom());
    send_word(start);
    for (int i = 8; i < size; i++) send_byte(8'($urandom()));
  endtask

  // Data block of any other type: skipped silently, including the empty case.
  task automatic send_skip_block();
    logic [31:0] size;
    logic [7:0]  blk_type;
    size = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    do blk_type = 8'($urandom()); while (blk_type == ROM_TYPE);
    send_byte(OP_BLOCK);
    send_byte(8'($urandom()));
    send_byte(blk_type);
    send_word(size);
    for (int i = 0; i < size; i++) send_byte(8'($urandom()));
  endtask

  // One well-formed command with random content, or a lone noise opcode.
  // Noise never starts a multi-byte command, so the stream stays aligned and
  // no stray end opcode can halt the parser early; argument bytes take any
  // value, the end opcode value included.
  task automatic send_command();
    int unsigned pick;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_byte($urandom_range(0, 1) ? OP_PSG_A : OP_PSG_B);
      send_byte(8'($urandom()));
    end else if (pick < 35) begin
      send_byte(ADDRESSED_OPS[$urandom_range(0, 4)]);
      send_byte(8'($urandom()));
      send_byte(8'($urandom()));
    end else if (pick < 45) begin
      send_byte(OP_WAIT_N);
      send_byte(8'($urandom()));
      send_byte(8'($urandom()));
    end else if (pick < 57) begin
      case ($urandom_range(0, 3))
        0:       send_byte(OP_WAIT_NTSC);
        1:       send_byte(OP_WAIT_PAL);
        default: send_byte({OP_WAIT_SHORT_HI, 4'($urandom())});
      endcase
    end else if (pick < 67) begin
      send_rom_block();
    end else if (pick < 75) begin
      send_skip_block();
    end else begin
      do b = 8'($urandom());
      while (b inside {OP_PSG_A, OP_PSG_B, OP_FM_BANK0, OP_FM_BANK1, OP_FM_ONE, OP_PCM,
                       OP_APU, OP_WAIT_N, OP_END, OP_BLOCK});
      send_byte(b);
    end
  endtask

  // Result side: draw a stall before each request, with calm stretches of
  // constant readiness, and keep ready up until the next result is taken.
  initial begin : result_pacing
    int unsigned stall;
    bit          calm;
    calm = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    logic [7:0]  opening [$];
    logic [16:0] rate;
    int unsigned per_phase;
    // Every opcode but the end and block opcodes once with field extremes, all at
    // the reset rate: both PSG forms, each addressed chip with both banks, the
    // longest explicit wait, both frame waits, the shortest and longest short
    // waits, and unknown opcodes at both ends of the byte range.
    opening = '{OP_PSG_A, 8'hFF, OP_PSG_B, 8'h00,
                OP_FM_BANK0, 8'h00, 8'hFF, OP_FM_BANK1, 8'hFF, 8'h00,
                OP_FM_ONE, 8'hA5, 8'h5A, OP_PCM, 8'h3C, 8'hC3, OP_APU, 8'h80, 8'h01,
                OP_WAIT_N, 8'hFF, 8'hFF, OP_WAIT_NTSC, OP_WAIT_PAL,
                {OP_WAIT_SHORT_HI, 4'h0}, {OP_WAIT_SHORT_HI, 4'hF}, 8'h00, 8'hFF};

    // Hold reset from time zero, then release it; it is never asserted again.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) send_byte(opening[i]);

    // Random commands under a series of rates; the rate changes only once
    // the parser has drained.
    per_phase = (TOTAL_BYTES - opening.size()) / RATE_PHASES;
    for (int p = 0; p < RATE_PHASES; p++) begin
      if (p < 5) rate = FIXED_RATES[p];
      else if (p == 5) rate = $urandom_range(8000, 96000);
      else rate = 17'($urandom());
      write_rate(rate);
      while (bytes_sent < opening.size() + (p + 1) * per_phase) send_command();
    end

    // End mark last of all: it halts the parser until reset, so everything
    // after it must be dropped without a result.
    send_byte(OP_END);
    repeat (6) send_byte(8'($urandom()));
    wait_drained();

    if (mismatches == 0 && owed_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Stop a hung run; the slowest correct run ends far earlier.
  initial begin : watchdog
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: sound_log_command_parser.f
+incdir+hw/rtl
hw/rtl/slcp_pkg.sv
hw/rtl/slcp_parser.sv
hw/rtl/slcp_scaler.sv
hw/rtl/sound_log_command_parser.sv
hw/rtl/slcp_checker.sv
tb/sound_log_command_parser_watch.sv
tb/tb_sound_log_command_parser.sv
